// ===== design/ipf_pkg.sv =====
// Package with the shared widths, sequencer states and divider handshake types.
package ipf_pkg;

  // Width of the value being factored.
  localparam int VALUE_BITS = 32;
  // Bits of the divider step counter.
  localparam int STEP_BITS = $clog2(VALUE_BITS);
  // Index of the last divider step.
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(VALUE_BITS - 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TWOS,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [VALUE_BITS-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [VALUE_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/ipf_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module ipf_divider import ipf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] dvs_r, dvs_nxt;
  logic [VALUE_BITS:0]   acc;
  logic [VALUE_BITS:0]   diff;

  // One shift and trial subtract per cycle.
  assign acc  = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff = acc - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (diff[VALUE_BITS]) begin
        rem_nxt = acc[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end else begin
        rem_nxt = diff[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end
      step_nxt = step_r + STEP_BITS'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== design/integer_prime_factorizer_unit.sv =====
// Top level: trial division sequencer around a shared iterative divider.
//
//   channel  direction  ports                              handshake
//   in       input      in_value                           in_valid / in_stall
//   out      output     out_prime_factor, out_last         out_valid / out_stall
//
// A value of 0 or 1 is accepted and then loaded; each factor of two is shifted out and
// then loaded. A trial division starts the divider, runs its 32 divider steps and is
// evaluated; a factor found adds a load step.
// A 32-bit value needs up to about 32768 trial divisions.
// in_stall is high from the accepted transfer until the last factor is loaded.
// Results wait in an output register while out_stall is high; the sequencer
// holds before loading the next one. Reset is synchronous and active low.
module integer_prime_factorizer_unit import ipf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_prime_factor,
  output logic                  out_last
);

  state_t                state_r, state_nxt;
  state_t                ret_r, ret_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic                  inner_r, inner_nxt;
  logic [VALUE_BITS-1:0] fac_r, fac_nxt;
  logic                  fac_last_r, fac_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_factor_r, out_factor_nxt;
  logic                  out_last_r, out_last_nxt;
  div_req_t              req;
  div_rsp_t              rsp;
  logic                  in_take;
  logic                  emit_go;
  logic                  small_in;
  logic                  bound_fail;
  logic                  divisible;
  logic                  quo_one;
  logic                  half_one;

  ipf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Shared decisions of the sequencer.
  assign in_take    = in_valid && (state_r == S_IDLE);
  assign emit_go    = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign small_in   = (in_value[VALUE_BITS-1:1] == '0);
  assign bound_fail = !inner_r && (div_r > rsp.quotient);
  assign divisible  = (rsp.remainder == '0);
  assign quo_one    = (rsp.quotient == VALUE_BITS'(1));
  assign half_one   = (rem_r[VALUE_BITS-1:1] == (VALUE_BITS-1)'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = small_in ? S_EMIT : S_TWOS;
      end
      S_TWOS: begin
        state_nxt = rem_r[0] ? S_DIV_START : S_EMIT;
      end
      S_DIV_START: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (rsp.done) begin
          if (bound_fail) begin
            state_nxt = (rem_r > VALUE_BITS'(1)) ? S_EMIT : S_IDLE;
          end else if (divisible) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DIV_START;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    ret_nxt        = ret_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    inner_nxt      = inner_r;
    fac_nxt        = fac_r;
    fac_last_nxt   = fac_last_r;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    req.start      = 1'b0;
    req.dividend   = rem_r;
    req.divisor    = div_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          rem_nxt      = in_value;
          fac_nxt      = in_value;
          fac_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
        end
      end
      S_TWOS: begin
        if (rem_r[0]) begin
          div_nxt   = VALUE_BITS'(3);
          inner_nxt = 1'b0;
        end else begin
          rem_nxt      = {1'b0, rem_r[VALUE_BITS-1:1]};
          fac_nxt      = VALUE_BITS'(2);
          fac_last_nxt = half_one;
          ret_nxt      = half_one ? S_IDLE : S_TWOS;
        end
      end
      S_DIV_START: begin
        req.start = 1'b1;
      end
      S_DIV_WAIT: begin
        if (rsp.done) begin
          if (bound_fail) begin
            fac_nxt      = rem_r;
            fac_last_nxt = 1'b1;
            ret_nxt      = S_IDLE;
          end else if (divisible) begin
            rem_nxt      = rsp.quotient;
            inner_nxt    = 1'b1;
            fac_nxt      = div_r;
            fac_last_nxt = quo_one;
            ret_nxt      = quo_one ? S_IDLE : S_DIV_START;
          end else begin
            div_nxt   = div_r + VALUE_BITS'(2);
            inner_nxt = 1'b0;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = fac_r;
          out_last_nxt   = fac_last_r;
        end
      end
      default: begin
        ret_nxt = S_IDLE;
      end
    endcase
  end

  // Registers: control state is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    inner_r      <= inner_nxt;
    fac_r        <= fac_nxt;
    fac_last_r   <= fac_last_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_prime_factor = out_factor_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // A factor below two can only be the echo of a zero or one input.
  a_small_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_prime_factor[VALUE_BITS-1:1] == '0)) |-> out_last)
    else $error("factor below two without last flag");

  // An accepted input transfer always starts work.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted input did not start the sequencer");
`endif

endmodule
